/* rtl/tdtt_pkg.sv */
package tdtt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 48;
  localparam int BYTES_W = 29;
  localparam int ENTRY_W = ADDR_W + BYTES_W;
  localparam int SLOT_W  = 6;
  localparam int REM_W   = 7;

  localparam logic [2:0] STATUS_HIT      = 3'd0;
  localparam logic [2:0] STATUS_INSERTED = 3'd1;
  localparam logic [2:0] STATUS_BAD_ADDR = 3'd2;
  localparam logic [2:0] STATUS_FULL     = 3'd3;
  localparam logic [2:0] STATUS_INV_DONE = 3'd4;

  localparam logic [5:0] DFMT_8_8_8_8  = 6'h08;
  localparam logic [5:0] DFMT_BC1      = 6'h0A;
  localparam logic [5:0] DFMT_BC2      = 6'h0B;
  localparam logic [5:0] DFMT_BC3      = 6'h0C;
  localparam logic [5:0] DFMT_RGBA8    = 6'h1A;
  localparam logic [5:0] DFMT_RGBA16F  = 6'h35;
  localparam logic [5:0] DFMT_RGBA32F  = 6'h39;
  localparam logic [2:0] NFMT_UINT     = 3'd4;

  localparam logic [2:0] FMT_BGRA8_UNORM = 3'd0;
  localparam logic [2:0] FMT_BC1         = 3'd1;
  localparam logic [2:0] FMT_BC2         = 3'd2;
  localparam logic [2:0] FMT_BC3         = 3'd3;
  localparam logic [2:0] FMT_RGBA8_UINT  = 3'd4;
  localparam logic [2:0] FMT_RGBA8_UNORM = 3'd5;
  localparam logic [2:0] FMT_RGBA16F     = 3'd6;
  localparam logic [2:0] FMT_RGBA32F     = 3'd7;

  localparam logic CMD_LOOKUP     = 1'b0;
  localparam logic CMD_INVALIDATE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [12:0]        width;
    logic [14:0]        height;
    logic [12:0]        mips;
    logic [2:0]         fmt;
    logic [BYTES_W-1:0] bytes;
  } desc_t;

  function automatic logic [2:0] map_format(input logic [5:0] dfmt, input logic [2:0] nfmt);
    logic [2:0] code;
    case (dfmt)
      DFMT_8_8_8_8: code = FMT_BGRA8_UNORM;
      DFMT_BC1:     code = FMT_BC1;
      DFMT_BC2:     code = FMT_BC2;
      DFMT_BC3:     code = FMT_BC3;
      DFMT_RGBA8:   code = (nfmt == NFMT_UINT) ? FMT_RGBA8_UINT : FMT_RGBA8_UNORM;
      DFMT_RGBA16F: code = FMT_RGBA16F;
      DFMT_RGBA32F: code = FMT_RGBA32F;
      default:      code = FMT_RGBA8_UNORM;
    endcase
    return code;
  endfunction

endpackage

/* rtl/texture_descriptor_tag_table.sv */
// Fully associative table of resident textures keyed by base address. A command is
// taken when start is high and busy is low; busy then stays high until the result.
// Each command walks the whole table through the entry memory, one entry a cycle,
// and then gives its result from a finish state; a lookup with address zero or
// an invalidate of size zero skips the walk and goes straight to the finish
// state. The result is shown for one cycle, marked by out_valid, and must
// be taken then: the receiver cannot stall. Valid bits clear at reset.
module texture_descriptor_tag_table
  import tdtt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [31:0]        in_desc_word0,
  input  logic [31:0]        in_desc_word1,
  input  logic [31:0]        in_desc_word2,
  input  logic [ADDR_W-1:0]  in_inv_address,
  input  logic [ADDR_W-1:0]  in_inv_size,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [ADDR_W-1:0]  out_base_address,
  output logic [12:0]        out_tex_width,
  output logic [14:0]        out_tex_height,
  output logic [12:0]        out_mip_count,
  output logic [2:0]         out_format_code,
  output logic [REM_W-1:0]   out_removed_count
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t state_r, state_nxt;

  desc_t              dec;
  desc_t              desc_r;
  logic               cmd_r;
  logic [ADDR_W-1:0]  inv_start_r;
  logic [ADDR_W:0]    inv_end_r;
  logic [CNT_W-1:0]   ctr_r;
  logic               cmp_en_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   hit_slot_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_slot_r;
  logic [REM_W-1:0]   removed_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [ADDR_W-1:0]  out_base_r;
  logic [12:0]        out_width_r;
  logic [14:0]        out_height_r;
  logic [12:0]        out_mips_r;
  logic [2:0]         out_fmt_r;
  logic [REM_W-1:0]   out_removed_r;

  logic               skip_in;
  logic               scan_rd;
  logic               scan_last;
  logic               ins_we;
  logic               bad_addr;
  logic [ENTRY_W-1:0] rd_entry;
  logic [ADDR_W-1:0]  rd_base;
  logic [BYTES_W-1:0] rd_bytes;
  logic [ADDR_W:0]    rd_end;
  logic               cur_valid;
  logic               overlap;

  tdtt_decode u_decode (
    .word0 (in_desc_word0),
    .word1 (in_desc_word1),
    .word2 (in_desc_word2),
    .desc  (dec)
  );

  tdtt_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (free_slot_r),
    .wdata ({desc_r.base, desc_r.bytes}),
    .raddr (ctr_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign busy      = (state_r != ST_IDLE);
  assign skip_in   = (in_cmd == CMD_INVALIDATE) ? (in_inv_size == '0) : (dec.base == '0);
  assign scan_last = (ctr_r == CNT_W'(TABLE_ENTRIES));
  assign scan_rd   = (state_r == ST_SCAN) && !scan_last;
  assign bad_addr  = (desc_r.base == '0);
  assign ins_we    = (state_r == ST_FIN) && (cmd_r == CMD_LOOKUP) && !bad_addr
                     && !found_r && free_found_r;

  assign rd_base   = rd_entry[ENTRY_W-1:BYTES_W];
  assign rd_bytes  = rd_entry[BYTES_W-1:0];
  assign rd_end    = {1'b0, rd_base} + {{(ADDR_W + 1 - BYTES_W){1'b0}}, rd_bytes};
  assign cur_valid = valid_r[cmp_idx_r];
  assign overlap   = ({1'b0, rd_base} < inv_end_r) && ({1'b0, inv_start_r} < rd_end);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = skip_in ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_en_r    <= scan_rd;
      cmp_idx_r   <= ctr_r[IDX_W-1:0];
      out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r        <= in_cmd;
            desc_r       <= dec;
            inv_start_r  <= in_inv_address;
            inv_end_r    <= {1'b0, in_inv_address} + {1'b0, in_inv_size};
            ctr_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            removed_r    <= '0;
          end
        end
        ST_SCAN: begin
          if (!scan_last) begin
            ctr_r <= ctr_r + CNT_W'(1);
          end
        end
        ST_FIN: begin
          out_valid_r <= 1'b1;
          if (cmd_r == CMD_INVALIDATE) begin
            out_status_r  <= STATUS_INV_DONE;
            out_slot_r    <= '0;
            out_base_r    <= '0;
            out_width_r   <= '0;
            out_height_r  <= '0;
            out_mips_r    <= '0;
            out_fmt_r     <= '0;
            out_removed_r <= removed_r;
          end else begin
            out_base_r    <= desc_r.base;
            out_width_r   <= desc_r.width;
            out_height_r  <= desc_r.height;
            out_mips_r    <= desc_r.mips;
            out_fmt_r     <= desc_r.fmt;
            out_removed_r <= '0;
            if (bad_addr) begin
              out_status_r <= STATUS_BAD_ADDR;
              out_slot_r   <= '0;
            end else if (found_r) begin
              out_status_r <= STATUS_HIT;
              out_slot_r   <= SLOT_W'(hit_slot_r);
            end else if (free_found_r) begin
              out_status_r <= STATUS_INSERTED;
              out_slot_r   <= SLOT_W'(free_slot_r);
            end else begin
              out_status_r <= STATUS_FULL;
              out_slot_r   <= '0;
            end
          end
          if (ins_we) begin
            valid_r[free_slot_r] <= 1'b1;
          end
        end
        default: ;
      endcase

      if (cmp_en_r) begin
        if (cmd_r == CMD_LOOKUP) begin
          if (cur_valid && (rd_base == desc_r.base) && !found_r) begin
            found_r    <= 1'b1;
            hit_slot_r <= cmp_idx_r;
          end
          if (!cur_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_slot_r  <= cmp_idx_r;
          end
        end else if (cur_valid && overlap) begin
          valid_r[cmp_idx_r] <= 1'b0;
          if (removed_r != {REM_W{1'b1}}) begin
            removed_r <= removed_r + REM_W'(1);
          end
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_base_address  = out_base_r;
  assign out_tex_width     = out_width_r;
  assign out_tex_height    = out_height_r;
  assign out_mip_count     = out_mips_r;
  assign out_format_code   = out_fmt_r;
  assign out_removed_count = out_removed_r;

endmodule

/* rtl/tdtt_ram.sv */
module tdtt_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tdtt_decode.sv */
module tdtt_decode
  import tdtt_pkg::*;
(
  input  logic [31:0] word0,
  input  logic [31:0] word1,
  input  logic [31:0] word2,
  output desc_t       desc
);

  logic [12:0] wid;
  logic [14:0] hgt;
  logic [26:0] area;

  assign wid  = {1'b0, word1[31:20]} + 13'd1;
  assign hgt  = {1'b0, word2[13:0]} + 15'd1;
  assign area = 27'(wid) * 27'(hgt);

  always_comb begin
    desc.base   = {word1[7:0], word0, 8'h00};
    desc.width  = wid;
    desc.height = hgt;
    desc.mips   = {1'b0, word1[19:8]} + 13'd1;
    desc.fmt    = map_format(word2[20:15], word2[22:20]);
    desc.bytes  = {area[BYTES_W-3:0], 2'b00};
  end

endmodule
